/* rtl/cpio_newc_stream_parser_top_macros.svh */
// Assertion macros for the cpio newc stream parser.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef CPIO_NEWC_STREAM_PARSER_TOP_MACROS_SVH
`define CPIO_NEWC_STREAM_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, off while reset is asserted.
`define CNSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising edge, also during reset.
`define CNSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CNSP_ASSERT(label, clk, rstn, prop, msg)
`define CNSP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/cnsp_pkg.sv */
// Types, constants and small decode functions for the cpio newc stream parser.
// No dependencies.
`default_nettype none

package cnsp_pkg;

    localparam int HEX_DIGITS = 8;
    localparam int CHAR_POS_W = $clog2(HEX_DIGITS);

    // Result kinds
    localparam logic [2:0] KIND_FIELD     = 3'd0;
    localparam logic [2:0] KIND_NAME      = 3'd1;
    localparam logic [2:0] KIND_DATA      = 3'd2;
    localparam logic [2:0] KIND_ENTRY_END = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    // Header field numbers
    localparam logic [3:0] FIELD_FILESIZE = 4'd6;
    localparam logic [3:0] FIELD_NAMESIZE = 4'd11;
    localparam logic [3:0] FIELD_LAST     = 4'd12;
    localparam logic [3:0] NUM_FIELDS     = 4'd13;

    localparam logic [CHAR_POS_W-1:0] MAGIC_LAST = CHAR_POS_W'(5);
    localparam logic [31:0]           TRAILER_LEN = 32'd11;

    typedef enum logic [6:0] {
        PH_MAGIC   = 7'b0000001,
        PH_FIELDS  = 7'b0000010,
        PH_NAME    = 7'b0000100,
        PH_NAMEPAD = 7'b0001000,
        PH_DATA    = 7'b0010000,
        PH_DATAPAD = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  digit;
    } hex_t;

    typedef struct packed {
        phase_t      phase;
        logic        load_name;
        logic        load_data;
        logic        ended;
    } seg_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [3:0]  index;
        logic [31:0] value;
        logic [7:0]  byte_val;
        logic        last;
        logic        trailer;
    } res_t;

    function automatic logic [7:0] magic_char(input logic [CHAR_POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            CHAR_POS_W'(0): c = "0";
            CHAR_POS_W'(1): c = "7";
            CHAR_POS_W'(2): c = "0";
            CHAR_POS_W'(3): c = "7";
            CHAR_POS_W'(4): c = "0";
            CHAR_POS_W'(5): c = "1";
            default:        c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "T";
            4'd1:    c = "R";
            4'd2:    c = "A";
            4'd3:    c = "I";
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "!";
            4'd8:    c = "!";
            4'd9:    c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h = '0;
        if (c >= "0" && c <= "9") begin
            h.ok    = 1'b1;
            h.digit = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            h.ok    = 1'b1;
            h.digit = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            h.ok    = 1'b1;
            h.digit = 4'(c - "A" + 8'd10);
        end
        return h;
    endfunction

    // Pick the next non-empty segment at or after p; ended when none is left.
    function automatic seg_t enter_segment(input phase_t p, input logic [31:0] nlen,
                                           input logic [31:0] dlen, input logic [1:0] olb);
        seg_t s;
        logic from_name;
        logic from_npad;
        logic from_data;
        s         = '0;
        s.phase   = PH_MAGIC;
        from_name = (p == PH_NAME);
        from_npad = from_name || (p == PH_NAMEPAD);
        from_data = from_npad || (p == PH_DATA);
        if (from_name && nlen != 32'd0) begin
            s.phase     = PH_NAME;
            s.load_name = 1'b1;
        end else if (from_npad && olb != 2'd0) begin
            s.phase = PH_NAMEPAD;
        end else if (from_data && dlen != 32'd0) begin
            s.phase     = PH_DATA;
            s.load_data = 1'b1;
        end else if (olb != 2'd0) begin
            s.phase = PH_DATAPAD;
        end else begin
            s.ended = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/cpio_newc_stream_parser_top.sv */
// cpio newc archive stream parser: magic check, hex header decode, name/data pass-through.
// Depends on cnsp_pkg and cpio_newc_stream_parser_top_macros.svh.
//
//  channel | ports            | direction | content
//  --------+------------------+-----------+------------------------------------------
//  s_      | valid/ready      | in        | s_in_byte: one raw archive byte per item
//  m_      | valid/ready      | out       | kind, field index/value, byte, entry end
//
// The parser state and the result register update at the edge that accepts the byte, so a
// new byte is taken every cycle while the output register is empty or m_ready is high.
// A result sits in the output register; s_ready stays high while it is being taken.
// Bytes that give no result (magic, partial hex digits, padding) are still accepted.
// Synchronous active-low reset returns to "expect magic"; after a format error all
// bytes are dropped until reset.
`default_nettype none

`include "cpio_newc_stream_parser_top_macros.svh"

module cpio_newc_stream_parser_top
    import cnsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_kind,
    output logic [3:0]       m_field_index,
    output logic [31:0]      m_field_value,
    output logic [7:0]       m_byte_value,
    output logic             m_entry_last,
    output logic             m_is_trailer
);

    phase_t                  phase_reg,     phase_next;
    logic [CHAR_POS_W-1:0]   char_pos_reg,  char_pos_next;
    logic [3:0]              field_num_reg, field_num_next;
    logic [31:0]             acc_reg,       acc_next;
    logic [31:0]             name_len_reg,  name_len_next;
    logic [31:0]             data_len_reg,  data_len_next;
    logic [31:0]             rem_reg,       rem_next;
    logic [1:0]              olb_reg,       olb_next;
    logic                    trailer_reg,   trailer_next;

    logic                    m_valid_reg,   m_valid_next;
    res_t                    out_reg;

    logic                    accept;
    res_t                    res;
    logic                    out_load;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign out_load = accept && res.valid;

    always_comb begin
        hex_t        hex;
        seg_t        seg;
        logic [1:0]  olb_inc;
        logic [31:0] acc_new;
        logic [31:0] rem_dec;
        logic [31:0] name_pos;
        logic [CHAR_POS_W-1:0] pos_new;
        logic        ended;

        phase_next     = phase_reg;
        char_pos_next  = char_pos_reg;
        field_num_next = field_num_reg;
        acc_next       = acc_reg;
        name_len_next  = name_len_reg;
        data_len_next  = data_len_reg;
        rem_next       = rem_reg;
        olb_next       = olb_reg;
        trailer_next   = trailer_reg;
        res            = '0;

        hex      = hex_decode(s_in_byte);
        olb_inc  = olb_reg + 2'd1;
        acc_new  = {acc_reg[27:0], hex.digit};
        pos_new  = char_pos_reg + CHAR_POS_W'(1);
        rem_dec  = rem_reg - 32'd1;
        name_pos = name_len_reg - rem_reg;
        seg      = '0;
        ended    = 1'b0;

        if (accept) begin
            if (phase_reg != PH_ERROR) begin
                olb_next = olb_inc;
            end
            case (phase_reg)
                PH_MAGIC: begin
                    if (char_pos_reg > MAGIC_LAST || s_in_byte != magic_char(char_pos_reg)) begin
                        phase_next = PH_ERROR;
                        res.valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                    end else if (char_pos_reg == MAGIC_LAST) begin
                        char_pos_next  = '0;
                        field_num_next = 4'd0;
                        acc_next       = 32'd0;
                        phase_next     = PH_FIELDS;
                    end else begin
                        char_pos_next = pos_new;
                    end
                end
                PH_FIELDS: begin
                    if (!hex.ok || field_num_reg >= NUM_FIELDS) begin
                        phase_next = PH_ERROR;
                        res.valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                    end else if (pos_new != '0) begin
                        acc_next      = acc_new;
                        char_pos_next = pos_new;
                    end else begin
                        res.valid     = 1'b1;
                        res.kind      = KIND_FIELD;
                        res.index     = field_num_reg;
                        res.value     = acc_new;
                        acc_next      = 32'd0;
                        char_pos_next = '0;
                        if (field_num_reg == FIELD_FILESIZE) begin
                            data_len_next = acc_new;
                        end
                        if (field_num_reg == FIELD_NAMESIZE) begin
                            name_len_next = acc_new;
                        end
                        if (field_num_reg == FIELD_LAST) begin
                            // header ends at offset 2 mod 4, so the entry cannot end here
                            field_num_next = 4'd0;
                            seg = enter_segment(PH_NAME, name_len_reg, data_len_reg, olb_inc);
                            phase_next = seg.phase;
                            if (seg.load_name) begin
                                rem_next = name_len_reg;
                            end else if (seg.load_data) begin
                                rem_next = data_len_reg;
                            end
                        end else begin
                            field_num_next = field_num_reg + 4'd1;
                        end
                    end
                end
                PH_NAME, PH_DATA: begin
                    if (phase_reg == PH_NAME && name_pos < TRAILER_LEN &&
                        s_in_byte != trailer_char(name_pos[3:0])) begin
                        trailer_next = 1'b0;
                    end
                    rem_next     = rem_dec;
                    res.valid    = 1'b1;
                    res.kind     = (phase_reg == PH_NAME) ? KIND_NAME : KIND_DATA;
                    res.byte_val = s_in_byte;
                    if (rem_dec == 32'd0) begin
                        seg = enter_segment((phase_reg == PH_NAME) ? PH_NAMEPAD : PH_DATAPAD,
                                            name_len_reg, data_len_reg, olb_inc);
                        ended      = seg.ended;
                        phase_next = seg.phase;
                        if (seg.load_data) begin
                            rem_next = data_len_reg;
                        end
                    end
                end
                PH_NAMEPAD, PH_DATAPAD: begin
                    // padding bytes are dropped unchecked
                    if (olb_inc == 2'd0) begin
                        seg = enter_segment((phase_reg == PH_NAMEPAD) ? PH_DATA : PH_DATAPAD,
                                            name_len_reg, data_len_reg, olb_inc);
                        ended      = seg.ended;
                        phase_next = seg.phase;
                        if (seg.load_data) begin
                            rem_next = data_len_reg;
                        end
                        if (seg.ended) begin
                            res.valid = 1'b1;
                            res.kind  = KIND_ENTRY_END;
                        end
                    end
                end
                PH_ERROR: begin
                    phase_next = PH_ERROR;
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase

            if (ended) begin
                res.last    = 1'b1;
                res.trailer = trailer_next && (name_len_reg >= TRAILER_LEN);
                // start the next entry
                phase_next     = PH_MAGIC;
                char_pos_next  = '0;
                field_num_next = 4'd0;
                acc_next       = 32'd0;
                name_len_next  = 32'd0;
                data_len_next  = 32'd0;
                rem_next       = 32'd0;
                olb_next       = 2'd0;
                trailer_next   = 1'b1;
            end
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_MAGIC;
            char_pos_reg  <= '0;
            field_num_reg <= 4'd0;
            acc_reg       <= 32'd0;
            name_len_reg  <= 32'd0;
            data_len_reg  <= 32'd0;
            rem_reg       <= 32'd0;
            olb_reg       <= 2'd0;
            trailer_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            char_pos_reg  <= char_pos_next;
            field_num_reg <= field_num_next;
            acc_reg       <= acc_next;
            name_len_reg  <= name_len_next;
            data_len_reg  <= data_len_next;
            rem_reg       <= rem_next;
            olb_reg       <= olb_next;
            trailer_reg   <= trailer_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_kind    = out_reg.kind;
    assign m_field_index = out_reg.index;
    assign m_field_value = out_reg.value;
    assign m_byte_value  = out_reg.byte_val;
    assign m_entry_last  = out_reg.last;
    assign m_is_trailer  = out_reg.trailer;

    `CNSP_ASSERT(a_error_sticks, aclk, aresetn, (out_load && res.kind == KIND_ERROR) |=> (phase_reg == PH_ERROR), "format error did not enter error phase")
    `CNSP_ASSERT(a_error_silent, aclk, aresetn, (phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR && !$rose(m_valid_reg)), "result produced in error phase")
    `CNSP_ASSERT(a_entry_restart, aclk, aresetn, (out_load && res.last) |=> (phase_reg == PH_MAGIC && olb_reg == 2'd0 && trailer_reg), "entry end did not restart parser")
    `CNSP_ASSERT(a_segment_nonempty, aclk, aresetn, (phase_reg == PH_NAME || phase_reg == PH_DATA) |-> (rem_reg != 32'd0), "name or data segment with no bytes left")
    `CNSP_ASSERT(a_trailer_on_last, aclk, aresetn, (m_valid && m_is_trailer) |-> m_entry_last, "trailer flag without entry end")

endmodule

`default_nettype wire
